// File: hdl/assert_macros.svh
// Assertion macros for the gradient noise block.
// Needs a clock and a reset signal in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GN_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gradient noise assertion failed");

// next-cycle implication
`define GN_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gradient noise assertion failed");

`endif

// File: hdl/gn_pkg.sv
// Constants, codes and types for the gradient noise block.
// Used by gn_ram and gradient_noise_1d_2d_3d; depends on nothing.
`default_nettype none

package gn_pkg;

   localparam int TABLE_SIZE = 256;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int FRAC_W     = 16;
   localparam int GRAD_W     = 16;
   localparam int COORD_W    = 32;
   localparam int PERM_W     = 8;
   localparam int OUT_W      = 18;

   localparam int S_W    = FRAC_W + 1;
   localparam int PROD_W = FRAC_W + 1 + GRAD_W;
   localparam int GM_W   = PROD_W - (GRAD_W - 1);
   localparam int VAL_W  = GM_W + 2;
   localparam int DIFF_W = VAL_W + 1;
   localparam int MP_W   = S_W + 1 + DIFF_W;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_1D   = 2'd1;
   localparam logic [1:0] MODE_2D   = 2'd2;
   localparam logic [1:0] MODE_3D   = 2'd3;

   typedef struct packed {
      logic [1:0]               mode;
      logic [IDX_W-1:0]         entry;
      logic [PERM_W-1:0]        perm;
      logic signed [GRAD_W-1:0] g1;
      logic signed [GRAD_W-1:0] g2x;
      logic signed [GRAD_W-1:0] g2y;
      logic signed [GRAD_W-1:0] g3x;
      logic signed [GRAD_W-1:0] g3y;
      logic signed [GRAD_W-1:0] g3z;
      logic [FRAC_W-1:0]        fx;
      logic [FRAC_W-1:0]        fy;
      logic [FRAC_W-1:0]        fz;
      logic [IDX_W-1:0]         by;
      logic [IDX_W-1:0]         bz;
   } ctl_type;

   typedef struct packed {
      logic [S_W-1:0] sx;
      logic [S_W-1:0] sy;
      logic [S_W-1:0] sz;
   } scurve_type;

endpackage

`default_nettype wire

// File: hdl/gn_ram.sv
// Table RAM, one write port and one registered read port, read before write.
// Depends on gn_pkg for the table depth.
`default_nettype none

module gn_ram #(
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [gn_pkg::IDX_W-1:0] rd_addr,
   input  wire logic                     wr_en,
   input  wire logic [gn_pkg::IDX_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [gn_pkg::TABLE_SIZE];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/gradient_noise_1d_2d_3d.sv
// Gradient noise in one, two or three dimensions: top level.
// Depends on gn_pkg, gn_ram and assert_macros.svh.
//
// Usage:
//   req channel: one item per handshake. req_tuser is the mode (load, 1D, 2D,
//   3D). A load writes one entry of every table; the tables are not cleared
//   by reset and must be loaded before noise items read them.
//   rsp channel: one item per request item, in order. rsp_tdata carries the
//   Q2.16 noise value (zero for a load), rsp_tuser flags a load.
//   Throughput: one item per cycle, unless the output stalls (see Stall).
//   The three lookup levels (cell permutation, hashed permutation, gradient)
//   each have a replicated table per corner read, so every level is one RAM
//   read per item.
//   Reset: empties the pipeline and the output register; tables keep contents.
//   Stall: while the result waits and rsp_tready is low the whole pipeline
//   holds and req_tready is low; a taken result frees it in the same cycle.
`default_nettype none
`include "assert_macros.svh"

module gradient_noise_1d_2d_3d (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // entry_index, perm_value, grad_one, grad_two_x, grad_two_y, grad_three_x,
   // grad_three_y, grad_three_z, coord_x, coord_y, coord_z
   input  wire logic [207:0] req_tdata,
   // mode
   input  wire logic [1:0]   req_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // noise_value, zero padding
   output      logic [23:0]  rsp_tdata,
   // was_load
   output      logic [0:0]   rsp_tuser
);

   localparam int NSTAGE = 10;
   localparam int G = gn_pkg::GRAD_W;
   localparam int F = gn_pkg::FRAC_W;
   localparam int I = gn_pkg::IDX_W;
   localparam int V = gn_pkg::VAL_W;
   localparam logic [F+1:0] THREE = (F+2)'(3) << F;
   localparam logic signed [V-1:0] OUT_MAX = V'((1 << (gn_pkg::OUT_W - 1)) - 1);
   localparam logic signed [V-1:0] OUT_MIN = -V'(1 << (gn_pkg::OUT_W - 1));

   function automatic logic signed [gn_pkg::MP_W-1:0] blend_mul(
      input logic [gn_pkg::S_W-1:0] s,
      input logic signed [V-1:0]    a,
      input logic signed [V-1:0]    b
   );
      logic signed [gn_pkg::DIFF_W-1:0] diff;
      diff = gn_pkg::DIFF_W'(b) - gn_pkg::DIFF_W'(a);
      return $signed({1'b0, s}) * diff;
   endfunction

   function automatic logic signed [V-1:0] blend_add(
      input logic signed [V-1:0]            a,
      input logic signed [gn_pkg::MP_W-1:0] mp
   );
      return V'(a + $signed(mp[F +: V]));
   endfunction

   logic adv;
   logic [NSTAGE:1] vld_ff;
   logic [NSTAGE:1] ld_ff;

   gn_pkg::ctl_type    ctl_in, ctl1_ff, ctl2_ff;
   logic [F-1:0]       t2x_ff, t2y_ff, t2z_ff;
   logic [F-1:0]       t2x_in, t2y_in, t2z_in;
   gn_pkg::scurve_type s_in, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff, s8_ff, s9_ff;
   logic [I-1:0]       i2_ff, j2_ff;
   logic [F-1:0]       fx3_ff, fy3_ff, fz3_ff;
   logic [1:0]         mode3_ff;

   logic [I-1:0]    pa_rd [2];
   logic [I-1:0]    pb_rd [4];
   logic [G-1:0]    g1_rd [2];
   logic [2*G-1:0]  g2_rd [4];
   logic [3*G-1:0]  g3_rd [8];

   logic signed [gn_pkg::GM_W-1:0] pr_in [8][3];
   logic signed [gn_pkg::GM_W-1:0] pr4_ff [8][3];
   logic signed [V-1:0]            dot_in [8];
   logic signed [V-1:0]            dot5_ff [8];
   logic signed [gn_pkg::MP_W-1:0] mx6_ff [4];
   logic signed [V-1:0]            ax6_ff [4];
   logic signed [V-1:0]            xl7_ff [4];
   logic signed [gn_pkg::MP_W-1:0] my8_ff [2];
   logic signed [V-1:0]            ay8_ff [2];
   logic signed [V-1:0]            yl9_ff [2];
   logic signed [gn_pkg::MP_W-1:0] mz10_ff;
   logic signed [V-1:0]            az10_ff;
   logic signed [V-1:0]            fin;

   logic                      rsp_valid_ff;
   logic                      rsp_load_ff;
   logic [gn_pkg::OUT_W-1:0]  noise_ff, noise_in;

   logic [I-1:0] bx0, bx1, by1_1, bz1_2;
   logic         ld0, ld1, ld2;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // unpack the request item
   always_comb begin
      ctl_in.mode  = req_tuser;
      ctl_in.entry = req_tdata[7:0];
      ctl_in.perm  = req_tdata[15:8];
      ctl_in.g1    = $signed(req_tdata[31:16]);
      ctl_in.g2x   = $signed(req_tdata[47:32]);
      ctl_in.g2y   = $signed(req_tdata[63:48]);
      ctl_in.g3x   = $signed(req_tdata[79:64]);
      ctl_in.g3y   = $signed(req_tdata[95:80]);
      ctl_in.g3z   = $signed(req_tdata[111:96]);
      ctl_in.fx    = req_tdata[112 +: F];
      ctl_in.fy    = req_tdata[144 +: F];
      ctl_in.fz    = req_tdata[176 +: F];
      ctl_in.by    = req_tdata[144 + F +: I];
      ctl_in.bz    = req_tdata[176 + F +: I];
      bx0          = req_tdata[112 + F +: I];
      bx1          = I'(bx0 + 1'b1);
      t2x_in       = F'((2*F)'(ctl_in.fx) * (2*F)'(ctl_in.fx) >> F);
      t2y_in       = F'((2*F)'(ctl_in.fy) * (2*F)'(ctl_in.fy) >> F);
      t2z_in       = F'((2*F)'(ctl_in.fz) * (2*F)'(ctl_in.fz) >> F);
   end

   assign ld0 = req_tvalid && adv && (req_tuser == gn_pkg::MODE_LOAD);
   assign ld1 = adv && vld_ff[1] && (ctl1_ff.mode == gn_pkg::MODE_LOAD);
   assign ld2 = adv && vld_ff[2] && (ctl2_ff.mode == gn_pkg::MODE_LOAD);

   // s-curve second multiply, masked for unused axes
   always_comb begin
      logic [F+1:0] kx, ky, kz;
      kx = THREE - {1'b0, ctl1_ff.fx, 1'b0};
      ky = THREE - {1'b0, ctl1_ff.fy, 1'b0};
      kz = THREE - {1'b0, ctl1_ff.fz, 1'b0};
      s_in.sx = gn_pkg::S_W'(((3*F+2)'(t2x_ff) * (3*F+2)'(kx)) >> F);
      s_in.sy = gn_pkg::S_W'(((3*F+2)'(t2y_ff) * (3*F+2)'(ky)) >> F);
      s_in.sz = gn_pkg::S_W'(((3*F+2)'(t2z_ff) * (3*F+2)'(kz)) >> F);
      if (ctl1_ff.mode == gn_pkg::MODE_1D) begin
         s_in.sy = '0;
      end
      if (ctl1_ff.mode != gn_pkg::MODE_3D) begin
         s_in.sz = '0;
      end
   end

   assign by1_1 = I'(ctl1_ff.by + 1'b1);
   assign bz1_2 = I'(ctl2_ff.bz + 1'b1);

   for (genvar k = 0; k < 2; k++) begin : g_perm_a
      gn_ram #(.WIDTH(I)) u_ram (
         .clock(clock), .rd_en(adv), .rd_addr((k == 1) ? bx1 : bx0),
         .wr_en(ld0), .wr_addr(ctl_in.entry), .wr_data(ctl_in.perm), .rd_data(pa_rd[k])
      );
   end

   for (genvar k = 0; k < 4; k++) begin : g_perm_b
      gn_ram #(.WIDTH(I)) u_ram (
         .clock(clock), .rd_en(adv),
         .rd_addr(I'(pa_rd[k % 2] + (((k / 2) == 1) ? by1_1 : ctl1_ff.by))),
         .wr_en(ld1), .wr_addr(ctl1_ff.entry), .wr_data(ctl1_ff.perm), .rd_data(pb_rd[k])
      );
   end

   for (genvar k = 0; k < 2; k++) begin : g_grad1
      gn_ram #(.WIDTH(G)) u_ram (
         .clock(clock), .rd_en(adv), .rd_addr((k == 1) ? j2_ff : i2_ff),
         .wr_en(ld2), .wr_addr(ctl2_ff.entry), .wr_data(ctl2_ff.g1), .rd_data(g1_rd[k])
      );
   end

   for (genvar k = 0; k < 4; k++) begin : g_grad2
      gn_ram #(.WIDTH(2*G)) u_ram (
         .clock(clock), .rd_en(adv), .rd_addr(pb_rd[k]),
         .wr_en(ld2), .wr_addr(ctl2_ff.entry), .wr_data({ctl2_ff.g2y, ctl2_ff.g2x}),
         .rd_data(g2_rd[k])
      );
   end

   for (genvar k = 0; k < 8; k++) begin : g_grad3
      gn_ram #(.WIDTH(3*G)) u_ram (
         .clock(clock), .rd_en(adv),
         .rd_addr(I'(pb_rd[k % 4] + ((k >= 4) ? bz1_2 : ctl2_ff.bz))),
         .wr_en(ld2), .wr_addr(ctl2_ff.entry),
         .wr_data({ctl2_ff.g3z, ctl2_ff.g3y, ctl2_ff.g3x}), .rd_data(g3_rd[k])
      );
   end

   // corner gradient times offset, k = dx + 2*dy + 4*dz
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         logic signed [G-1:0]      gx, gy, gz;
         logic signed [F:0]        rx, ry, rz;
         logic signed [gn_pkg::PROD_W-1:0] px, py, pz;
         gx = '0;
         gy = '0;
         gz = '0;
         case (mode3_ff)
            gn_pkg::MODE_1D: begin
               if (k < 2) begin
                  gx = $signed(g1_rd[k % 2]);
               end
            end
            gn_pkg::MODE_2D: begin
               if (k < 4) begin
                  gx = $signed(g2_rd[k % 4][G-1:0]);
                  gy = $signed(g2_rd[k % 4][2*G-1:G]);
               end
            end
            gn_pkg::MODE_3D: begin
               gx = $signed(g3_rd[k][G-1:0]);
               gy = $signed(g3_rd[k][2*G-1:G]);
               gz = $signed(g3_rd[k][3*G-1:2*G]);
            end
            default: begin
               gx = '0;
            end
         endcase
         rx = $signed({k[0], fx3_ff});
         ry = $signed({k[1], fy3_ff});
         rz = $signed({k[2], fz3_ff});
         px = rx * gx;
         py = ry * gy;
         pz = rz * gz;
         pr_in[k][0] = px[gn_pkg::PROD_W-1:G-1];
         pr_in[k][1] = py[gn_pkg::PROD_W-1:G-1];
         pr_in[k][2] = pz[gn_pkg::PROD_W-1:G-1];
      end
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         dot_in[k] = V'(pr4_ff[k][0]) + V'(pr4_ff[k][1]) + V'(pr4_ff[k][2]);
      end
   end

   assign fin = blend_add(az10_ff, mz10_ff);

   always_comb begin
      if (ld_ff[NSTAGE]) begin
         noise_in = '0;
      end else if (fin > OUT_MAX) begin
         noise_in = OUT_MAX[gn_pkg::OUT_W-1:0];
      end else if (fin < OUT_MIN) begin
         noise_in = OUT_MIN[gn_pkg::OUT_W-1:0];
      end else begin
         noise_in = fin[gn_pkg::OUT_W-1:0];
      end
   end

   // control: valid and load flags per stage, output register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         ld_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[NSTAGE-1:1], req_tvalid};
         ld_ff        <= {ld_ff[NSTAGE-1:1], req_tuser == gn_pkg::MODE_LOAD};
         rsp_valid_ff <= vld_ff[NSTAGE];
      end
   end

   // datapath: advance all stages together
   always_ff @(posedge clock) begin
      if (adv) begin
         ctl1_ff  <= ctl_in;
         t2x_ff   <= t2x_in;
         t2y_ff   <= t2y_in;
         t2z_ff   <= t2z_in;
         ctl2_ff  <= ctl1_ff;
         s2_ff    <= s_in;
         i2_ff    <= pa_rd[0];
         j2_ff    <= pa_rd[1];
         fx3_ff   <= ctl2_ff.fx;
         fy3_ff   <= ctl2_ff.fy;
         fz3_ff   <= ctl2_ff.fz;
         mode3_ff <= ctl2_ff.mode;
         s3_ff    <= s2_ff;
         s4_ff    <= s3_ff;
         pr4_ff   <= pr_in;
         s5_ff    <= s4_ff;
         dot5_ff  <= dot_in;
         s6_ff    <= s5_ff;
         for (int m = 0; m < 4; m++) begin
            mx6_ff[m] <= blend_mul(s5_ff.sx, dot5_ff[2*m], dot5_ff[2*m+1]);
            ax6_ff[m] <= dot5_ff[2*m];
            xl7_ff[m] <= blend_add(ax6_ff[m], mx6_ff[m]);
         end
         s7_ff    <= s6_ff;
         s8_ff    <= s7_ff;
         for (int m = 0; m < 2; m++) begin
            my8_ff[m] <= blend_mul(s7_ff.sy, xl7_ff[2*m], xl7_ff[2*m+1]);
            ay8_ff[m] <= xl7_ff[2*m];
            yl9_ff[m] <= blend_add(ay8_ff[m], my8_ff[m]);
         end
         s9_ff    <= s8_ff;
         mz10_ff  <= blend_mul(s9_ff.sz, yl9_ff[0], yl9_ff[1]);
         az10_ff  <= yl9_ff[0];
         noise_ff    <= noise_in;
         rsp_load_ff <= ld_ff[NSTAGE];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(24 - gn_pkg::OUT_W)'(0), noise_ff};
   assign rsp_tuser  = rsp_load_ff;

   `GN_ASSERT_IMP(a_load_zero, rsp_valid_ff && rsp_load_ff, noise_ff == '0)
   `GN_ASSERT_IMP(a_blocked_input, rsp_valid_ff && !rsp_tready, !req_tready)
   `GN_ASSERT_NEXT(a_stall_freeze, !adv, $stable(vld_ff) && $stable(noise_ff))
   `GN_ASSERT_NEXT(a_accept_enters, req_tvalid && req_tready, vld_ff[1])

endmodule

`default_nettype wire
